// ===== rtl/crc16fr_pkg.sv =====
// ----------------------------------------------------------------------------
// crc16fr_pkg
// Shared widths, register indexes, result kinds and the byte-wide CRC-16 step
// for the SOF/LEN/CMD/PAYLOAD/CRC16 frame receiver.
// ----------------------------------------------------------------------------
package crc16fr_pkg;

	localparam int BYTE_W = 8;
	localparam int LEN_W  = 16;
	localparam int CRC_W  = 16;
	localparam int KIND_W = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [CRC_W-1:0]  crc_t;
	typedef logic [KIND_W-1:0] kind_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	localparam cfg_idx_t REG_START_BYTE  = 2'd0;
	localparam cfg_idx_t REG_MAX_PAYLOAD = 2'd1;
	localparam cfg_idx_t REG_STATUS_CMD  = 2'd2;

	localparam byte_t START_BYTE_RST  = 8'hAA;
	localparam len_t  MAX_PAYLOAD_RST = 16'd512;
	localparam byte_t STATUS_CMD_RST  = 8'h10;

	localparam kind_t KIND_PAYLOAD   = 3'd0;
	localparam kind_t KIND_GOOD      = 3'd1;
	localparam kind_t KIND_CRC_BAD   = 3'd2;
	localparam kind_t KIND_DROPPED   = 3'd3;
	localparam kind_t KIND_LINK_LOST = 3'd4;

	localparam crc_t CRC_POLY = 16'h1021;
	localparam crc_t CRC_INIT = 16'hFFFF;

	function automatic crc_t crc16_byte(input crc_t crc_in, input byte_t data);
		crc_t c;
		c = crc_in ^ {data, 8'h00};
		for (int i = 0; i < BYTE_W; i++) begin
			if (c[CRC_W-1])
				c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			else
				c = {c[CRC_W-2:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// ===== rtl/crc16fr_rx_if.sv =====
// ----------------------------------------------------------------------------
// crc16fr_rx_if
// Receive channel: one received byte or a timeout event per word.
// ----------------------------------------------------------------------------
interface crc16fr_rx_if
	import crc16fr_pkg::*;
();
	logic  valid;
	logic  ready;
	byte_t rx_byte;
	logic  timeout;

	modport source (output valid, output rx_byte, output timeout, input ready);
	modport sink   (input valid, input rx_byte, input timeout, output ready);
endinterface

// ===== rtl/crc16fr_res_if.sv =====
// ----------------------------------------------------------------------------
// crc16fr_res_if
// Result channel: payload bytes and frame verdicts.
// ----------------------------------------------------------------------------
interface crc16fr_res_if
	import crc16fr_pkg::*;
();
	logic  valid;
	logic  ready;
	kind_t out_kind;
	byte_t data_byte;
	byte_t command;
	len_t  length;
	logic  is_status;
	logic  link_up;
	logic  last;

	modport source (output valid, output out_kind, output data_byte, output command,
		output length, output is_status, output link_up, output last, input ready);
	modport sink   (input valid, input out_kind, input data_byte, input command,
		input length, input is_status, input link_up, input last, output ready);
endinterface

// ===== rtl/crc16fr_cfg_if.sv =====
// ----------------------------------------------------------------------------
// crc16fr_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface crc16fr_cfg_if
	import crc16fr_pkg::*;
();
	logic      valid;
	logic      ready;
	cfg_idx_t  index;
	cfg_data_t data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/crc16_frame_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// crc16_frame_receiver_unit
// Deframes SOF | LEN(LE) | CMD | PAYLOAD | CRC16(LE) from a byte stream,
// streams payload bytes and reports a verdict per frame.
//
//   channel  dir  word
//   rx       in   rx_byte, timeout
//   res      out  out_kind, data_byte, command, length, is_status, link_up, last
//   cfg      in   index, data (start_byte, max_payload, status_command)
//
// One word per cycle while res is not stalled; a word goes from rx to res
// through the input register, then frame state update with byte-wide CRC into
// the result register. A stalled res holds its word and the input register;
// rx keeps accepting while the input register is free. cfg is always ready.
// arst_n clears the frame state, link flag and both valid flags.
// ----------------------------------------------------------------------------
module crc16_frame_receiver_unit
	import crc16fr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	crc16fr_rx_if.sink   rx,
	crc16fr_res_if.source res,
	crc16fr_cfg_if.sink  cfg
);

	localparam logic [2:0] PH_HUNT   = 3'd0;
	localparam logic [2:0] PH_LEN_LO = 3'd1;
	localparam logic [2:0] PH_LEN_HI = 3'd2;
	localparam logic [2:0] PH_CMD    = 3'd3;
	localparam logic [2:0] PH_DATA   = 3'd4;
	localparam logic [2:0] PH_CRC_LO = 3'd5;
	localparam logic [2:0] PH_CRC_HI = 3'd6;

	byte_t start_byte_q;
	len_t  max_payload_q;
	byte_t status_cmd_q;

	logic  valid_s1;
	byte_t byte_s1;
	logic  tmo_s1;
	logic  adv_s1;

	logic [2:0] phase_q, phase_d;
	len_t  len_q, len_d;
	byte_t cmd_q, cmd_d;
	len_t  cnt_q, cnt_d;
	crc_t  crc_q, crc_d;
	byte_t crc_lo_q, crc_lo_d;
	logic  link_q, link_d;

	logic  emit;
	kind_t kind;
	byte_t dbyte;
	logic  known;
	logic  last_bit;

	logic  out_valid_q;
	kind_t out_kind_q;
	byte_t out_data_q;
	byte_t out_cmd_q;
	len_t  out_len_q;
	logic  out_status_q;
	logic  out_link_q;
	logic  out_last_q;

	// config writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q  <= START_BYTE_RST;
			max_payload_q <= MAX_PAYLOAD_RST;
			status_cmd_q  <= STATUS_CMD_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_START_BYTE:  start_byte_q  <= cfg.data[BYTE_W-1:0];
				REG_MAX_PAYLOAD: max_payload_q <= cfg.data[LEN_W-1:0];
				REG_STATUS_CMD:  status_cmd_q  <= cfg.data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	assign adv_s1   = valid_s1 && (!out_valid_q || res.ready);
	assign rx.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (rx.valid && rx.ready)
			valid_s1 <= 1'b1;
		else if (adv_s1)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
			tmo_s1  <= rx.timeout;
		end
	end

	// frame state update
	always_comb begin
		phase_d  = phase_q;
		len_d    = len_q;
		cmd_d    = cmd_q;
		cnt_d    = cnt_q;
		crc_d    = crc_q;
		crc_lo_d = crc_lo_q;
		link_d   = link_q;
		emit     = 1'b0;
		kind     = KIND_PAYLOAD;
		dbyte    = '0;
		known    = 1'b1;
		last_bit = 1'b0;
		if (tmo_s1) begin
			if (phase_q == PH_HUNT) begin
				if (link_q) begin
					link_d = 1'b0;
					cmd_d  = '0;
					len_d  = '0;
					emit   = 1'b1;
					kind   = KIND_LINK_LOST;
					known  = 1'b0;
				end
			end else begin
				phase_d  = PH_HUNT;
				emit     = 1'b1;
				kind     = KIND_DROPPED;
				known    = (phase_q >= PH_DATA);
				last_bit = 1'b1;
			end
		end else begin
			unique case (phase_q)
				PH_HUNT: begin
					if (byte_s1 == start_byte_q) begin
						phase_d  = PH_LEN_LO;
						len_d    = '0;
						cmd_d    = '0;
						cnt_d    = '0;
						crc_d    = CRC_INIT;
						crc_lo_d = '0;
					end
				end
				PH_LEN_LO: begin
					len_d   = {8'h00, byte_s1};
					crc_d   = crc16_byte(crc_q, byte_s1);
					phase_d = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					len_d   = {byte_s1, len_q[7:0]};
					crc_d   = crc16_byte(crc_q, byte_s1);
					phase_d = PH_CMD;
				end
				PH_CMD: begin
					cmd_d = byte_s1;
					crc_d = crc16_byte(crc_q, byte_s1);
					cnt_d = '0;
					if (len_q > max_payload_q) begin
						phase_d  = PH_HUNT;
						emit     = 1'b1;
						kind     = KIND_DROPPED;
						last_bit = 1'b1;
					end else if (len_q == '0) begin
						phase_d = PH_CRC_LO;
					end else begin
						phase_d = PH_DATA;
					end
				end
				PH_DATA: begin
					crc_d = crc16_byte(crc_q, byte_s1);
					cnt_d = cnt_q + 16'd1;
					if (cnt_d == len_q)
						phase_d = PH_CRC_LO;
					emit  = 1'b1;
					kind  = KIND_PAYLOAD;
					dbyte = byte_s1;
				end
				PH_CRC_LO: begin
					crc_lo_d = byte_s1;
					phase_d  = PH_CRC_HI;
				end
				PH_CRC_HI: begin
					phase_d  = PH_HUNT;
					emit     = 1'b1;
					last_bit = 1'b1;
					if ({byte_s1, crc_lo_q} == crc_q) begin
						link_d = 1'b1;
						kind   = KIND_GOOD;
					end else begin
						kind   = KIND_CRC_BAD;
					end
				end
				default: phase_d = PH_HUNT;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			len_q    <= '0;
			cmd_q    <= '0;
			cnt_q    <= '0;
			crc_q    <= CRC_INIT;
			crc_lo_q <= '0;
			link_q   <= 1'b0;
		end else if (adv_s1) begin
			phase_q  <= phase_d;
			len_q    <= len_d;
			cmd_q    <= cmd_d;
			cnt_q    <= cnt_d;
			crc_q    <= crc_d;
			crc_lo_q <= crc_lo_d;
			link_q   <= link_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv_s1)
			out_valid_q <= emit;
		else if (res.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_kind_q   <= kind;
			out_data_q   <= dbyte;
			out_cmd_q    <= cmd_d;
			out_len_q    <= len_d;
			out_status_q <= known && (cmd_d == status_cmd_q);
			out_link_q   <= link_d;
			out_last_q   <= last_bit;
		end
	end

	assign res.valid     = out_valid_q;
	assign res.out_kind  = out_kind_q;
	assign res.data_byte = out_data_q;
	assign res.command   = out_cmd_q;
	assign res.length    = out_len_q;
	assign res.is_status = out_status_q;
	assign res.link_up   = out_link_q;
	assign res.last      = out_last_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res.ready |=> out_valid_q)
		else $error("held result lost");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PH_CRC_HI)
		else $error("phase out of range");

	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_last_q |-> (out_kind_q == KIND_GOOD ||
			out_kind_q == KIND_CRC_BAD || out_kind_q == KIND_DROPPED))
		else $error("last on non-verdict");

	a_link_lost: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_kind_q == KIND_LINK_LOST |-> !out_link_q && !out_status_q)
		else $error("link lost with link up");

	a_good_link: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && emit && kind == KIND_GOOD |=> link_q)
		else $error("good frame did not raise link");

endmodule
